// ===== rtl/core/bmct_pkg.sv =====
// ----------------------------------------------------------------------------
// bmct_pkg
// Shared types, constants and winding tables for the box mesh tessellator.
// ----------------------------------------------------------------------------
package bmct_pkg;

    localparam int MAX_CELLS_DEFAULT = 256;
    localparam int DIM_W    = 31;
    localparam int DIV_W    = 31;
    localparam int IDX_W    = 8;
    localparam int K_W      = IDX_W + 1;
    localparam int PROD_W   = DIM_W + K_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int POS_W    = 32;
    localparam int TEX_W    = 17;
    localparam int TEX_ONE  = 65536;
    localparam int NUM_DIV  = 11;
    localparam int NUM_FACE = 6;
    localparam int NUM_VERT = 6;
    localparam int ADDR_W   = 4;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_DIVS   = 2'd3;

    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_BACK   = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_LEFT   = 3'd4;
    localparam logic [2:0] FACE_RIGHT  = 3'd5;

    localparam logic [5:0] OFF_A_P0 = 6'b110001;
    localparam logic [5:0] OFF_A_P1 = 6'b011100;
    localparam logic [5:0] FACE_PAT = 6'b010110;

    function automatic logic off_a(input logic pat, input logic [2:0] k);
        off_a = pat ? OFF_A_P1[k] : OFF_A_P0[k];
    endfunction

    function automatic logic off_b(input logic pat, input logic [2:0] k);
        off_b = pat ? OFF_A_P0[k] : OFF_A_P1[k];
    endfunction

    typedef struct packed {
        logic [DIM_W-1:0] box_length;
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
        logic [7:0]       edge_divisions;
    } cfg_t;

endpackage

// ===== rtl/core/box_mesh_cell_tessellator.sv =====
// ----------------------------------------------------------------------------
// box_mesh_cell_tessellator
// Emit the 36 vertices of one grid cell on all six faces of a box.
// A cell first passes a 31-step serial divider, then its vertices are sequenced.
// Throughput: one vertex per cycle while a cell is queued and m_tready is high.
// Reset: asynchronous, clears control; registers return to 1.0 and 0 divisions.
// ----------------------------------------------------------------------------
module box_mesh_cell_tessellator
    import bmct_pkg::*;
#(
    parameter int MAX_CELLS_PER_EDGE = MAX_CELLS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // cell_i, cell_j
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,   // pos_x, pos_y, pos_z, normal_x/y/z, tex_u, tex_v
    output logic                m_tlast
);

    localparam int N_W  = $clog2(MAX_CELLS_PER_EDGE + 1);
    localparam int NF_W = (N_W > 9) ? N_W : 9;
    localparam int RW   = N_W + 3;
    localparam int EN_W = 2 * IDX_W + 3 * DIV_W + 8 * DIV_W + 8 * RW;

    cfg_t            cfg_reg;
    logic [NF_W-1:0] n_full;
    logic [N_W-1:0]  n;
    logic            push, q_full, pop, not_empty;
    logic [EN_W-1:0] push_data, head;

    assign pready = 1'b1;
    assign n_full = NF_W'(cfg_reg.edge_divisions) + NF_W'(1);
    assign n      = (n_full > NF_W'(MAX_CELLS_PER_EDGE)) ? N_W'(MAX_CELLS_PER_EDGE)
                                                         : N_W'(n_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_length     <= DIM_W'(TEX_ONE);
            cfg_reg.box_width      <= DIM_W'(TEX_ONE);
            cfg_reg.box_height     <= DIM_W'(TEX_ONE);
            cfg_reg.edge_divisions <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_LENGTH: cfg_reg.box_length     <= pwdata[DIM_W-1:0];
                REG_WIDTH:  cfg_reg.box_width      <= pwdata[DIM_W-1:0];
                REG_HEIGHT: cfg_reg.box_height     <= pwdata[DIM_W-1:0];
                default:    cfg_reg.edge_divisions <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LENGTH: prdata = {1'b0, cfg_reg.box_length};
            REG_WIDTH:  prdata = {1'b0, cfg_reg.box_width};
            REG_HEIGHT: prdata = {1'b0, cfg_reg.box_height};
            default:    prdata = {24'b0, cfg_reg.edge_divisions};
        endcase
    end

    bmct_front #(.N_W(N_W), .RW(RW), .EN_W(EN_W)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .n         (n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    bmct_queue #(.EN_W(EN_W)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    bmct_back #(.N_W(N_W), .RW(RW), .EN_W(EN_W)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .n         (n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/bmct_front.sv =====
// ----------------------------------------------------------------------------
// bmct_front
// Accept a cell, run the step and texture divisions bit-serially, push result.
// ----------------------------------------------------------------------------
module bmct_front
    import bmct_pkg::*;
#(
    parameter int N_W  = 9,
    parameter int RW   = N_W + 3,
    parameter int EN_W = 2 * IDX_W + 3 * DIV_W + 8 * DIV_W + 8 * RW
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic [N_W-1:0]  n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,   // cell_i, cell_j
    output logic            push,
    input  logic            q_full,
    output logic [EN_W-1:0] push_data
);

    logic             hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0] hold_ci_reg, hold_cj_reg;
    logic [IDX_W-1:0] item_ci_reg, item_cj_reg;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg;
    logic [DIV_W-1:0] quo_reg [NUM_DIV];
    logic [RW-1:0]    rem_reg [NUM_DIV];
    logic [RW-1:0]    dvs     [NUM_DIV];
    logic [DIV_W-1:0] dvd     [NUM_DIV];
    logic [K_W-1:0]   kv      [4];
    logic             start;

    assign s_tready = !hold_valid_reg;
    assign start    = hold_valid_reg && !busy_reg && !done_reg;
    assign push     = done_reg && !q_full;

    always_comb
    begin
        kv[0] = {1'b0, hold_ci_reg};
        kv[1] = {1'b0, hold_ci_reg} + K_W'(1);
        kv[2] = {1'b0, hold_cj_reg};
        kv[3] = {1'b0, hold_cj_reg} + K_W'(1);
        dvd[0] = DIV_W'(cfg.box_length);
        dvd[1] = DIV_W'(cfg.box_height);
        dvd[2] = DIV_W'(cfg.box_width);
        dvs[0] = RW'(n);
        dvs[1] = RW'(n);
        dvs[2] = RW'(n);
        for (int d = 0; d < 4; d++)
        begin
            dvd[3 + d] = DIV_W'({kv[d], 16'b0});
            dvd[7 + d] = DIV_W'({kv[d], 16'b0});
            dvs[3 + d] = RW'(n) * RW'(3);
            dvs[7 + d] = RW'(n) * RW'(2);
        end
        hold_valid_next = hold_valid_reg;
        if (start)
            hold_valid_next = 1'b0;
        if (s_tvalid && s_tready)
            hold_valid_next = 1'b1;
        busy_next = busy_reg;
        done_next = done_reg;
        if (push)
            done_next = 1'b0;
        if (start)
            busy_next = 1'b1;
        if (busy_reg && cnt_reg == 5'(DIV_W - 1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            if (start)
                cnt_reg <= '0;
            else if (busy_reg)
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [RW-1:0] sh;
        if (s_tvalid && s_tready)
        begin
            hold_ci_reg <= s_tdata[7:0];
            hold_cj_reg <= s_tdata[15:8];
        end
        if (start)
        begin
            item_ci_reg <= hold_ci_reg;
            item_cj_reg <= hold_cj_reg;
            for (int d = 0; d < NUM_DIV; d++)
            begin
                quo_reg[d] <= dvd[d];
                rem_reg[d] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int d = 0; d < NUM_DIV; d++)
            begin
                sh = {rem_reg[d][RW-2:0], quo_reg[d][DIV_W-1]};
                if (sh >= dvs[d])
                begin
                    rem_reg[d] <= sh - dvs[d];
                    quo_reg[d] <= {quo_reg[d][DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[d] <= sh;
                    quo_reg[d] <= {quo_reg[d][DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        push_data = {item_cj_reg, item_ci_reg,
                     quo_reg[0], quo_reg[1], quo_reg[2],
                     quo_reg[3], quo_reg[4], quo_reg[5], quo_reg[6],
                     rem_reg[3], rem_reg[4], rem_reg[5], rem_reg[6],
                     quo_reg[7], quo_reg[8], quo_reg[9], quo_reg[10],
                     rem_reg[7], rem_reg[8], rem_reg[9], rem_reg[10]};
    end

endmodule

// ===== rtl/core/bmct_queue.sv =====
// ----------------------------------------------------------------------------
// bmct_queue
// Two-entry queue between the divider front and the vertex back end.
// ----------------------------------------------------------------------------
module bmct_queue
    import bmct_pkg::*;
#(
    parameter int EN_W = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [EN_W-1:0] push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output logic [EN_W-1:0] head
);

    logic [EN_W-1:0] mem_reg [2];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/bmct_back.sv =====
// ----------------------------------------------------------------------------
// bmct_back
// Sequence 36 vertices per cell: product stage, then sum, saturate, register.
// ----------------------------------------------------------------------------
module bmct_back
    import bmct_pkg::*;
#(
    parameter int N_W  = 9,
    parameter int RW   = N_W + 3,
    parameter int EN_W = 2 * IDX_W + 3 * DIV_W + 8 * DIV_W + 8 * RW
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic [N_W-1:0]  n,
    input  logic            not_empty,
    input  logic [EN_W-1:0] head,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [135:0]    m_tdata,   // pos_x, pos_y, pos_z, normal_x/y/z, tex_u, tex_v
    output logic            m_tlast
);

    logic [IDX_W-1:0] e_ci, e_cj;
    logic [DIV_W-1:0] e_step [3];
    logic [DIV_W-1:0] e_uq [4];
    logic [DIV_W-1:0] e_vq [4];
    logic [RW-1:0]    e_ur [4];
    logic [RW-1:0]    e_vr [4];

    assign {e_cj, e_ci, e_step[0], e_step[1], e_step[2],
            e_uq[0], e_uq[1], e_uq[2], e_uq[3], e_ur[0], e_ur[1], e_ur[2], e_ur[3],
            e_vq[0], e_vq[1], e_vq[2], e_vq[3], e_vr[0], e_vr[1], e_vr[2], e_vr[3]} = head;

    logic [2:0]        face_reg, vert_reg;
    logic              a_valid_reg;
    logic [2:0]        a_face_reg;
    logic              a_last_reg;
    logic [PROD_W-1:0] a_pa_reg, a_pb_reg;
    logic [DIV_W-1:0]  a_uq_reg, a_vq_reg;
    logic [RW-1:0]     a_ur_reg, a_vr_reg;
    logic              m_valid_reg;
    logic [135:0]      m_data_reg;
    logic              m_last_reg;

    logic              en, issue, last_v;
    logic              pat, oa, ob;
    logic [K_W-1:0]    ia, jb;
    logic [DIV_W-1:0]  step_a, step_b;
    logic [1:0]        ku, kv;

    assign en       = !m_valid_reg || m_tready;
    assign issue    = en && not_empty;
    assign last_v   = face_reg == FACE_RIGHT && vert_reg == 3'(NUM_VERT - 1);
    assign pop      = issue && last_v;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        pat    = FACE_PAT[face_reg];
        oa     = off_a(pat, vert_reg);
        ob     = off_b(pat, vert_reg);
        ia     = {1'b0, e_ci} + K_W'(oa);
        jb     = {1'b0, e_cj} + K_W'(ob);
        step_a = (face_reg == FACE_LEFT || face_reg == FACE_RIGHT) ? e_step[2] : e_step[0];
        step_b = (face_reg == FACE_TOP || face_reg == FACE_BOTTOM) ? e_step[2] : e_step[1];
        ku     = (face_reg == FACE_LEFT) ? {1'b1, ob} : {1'b0, oa};
        kv     = (face_reg == FACE_LEFT) ? {1'b0, oa} : {1'b1, ob};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg    <= FACE_FRONT;
            vert_reg    <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= not_empty;
            m_valid_reg <= a_valid_reg;
            if (not_empty)
            begin
                if (vert_reg == 3'(NUM_VERT - 1))
                begin
                    vert_reg <= '0;
                    face_reg <= last_v ? FACE_FRONT : face_reg + 3'd1;
                end
                else
                    vert_reg <= vert_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_face_reg <= face_reg;
            a_last_reg <= last_v;
            a_pa_reg   <= PROD_W'(step_a) * PROD_W'(ia);
            a_pb_reg   <= PROD_W'(step_b) * PROD_W'(jb);
            a_uq_reg   <= e_uq[ku];
            a_ur_reg   <= e_ur[ku];
            a_vq_reg   <= e_vq[kv];
            a_vr_reg   <= e_vr[kv];
        end
    end

    logic signed [SUM_W-1:0] xh, yh, zh, pa, pb, px, py, pz;
    logic [1:0]              nx, ny, nz;
    logic [1:0]              col;
    logic                    row;
    logic [16:0]             ua, va;
    logic [1:0]              ub;
    logic [RW-1:0]           bn, du, dv;
    logic                    cu, cv;
    logic [DIV_W:0]          us, vs;
    logic [TEX_W-1:0]        tu, tv;

    function automatic logic [POS_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(32'sh7fffffff))
            sat = 32'h7fffffff;
        else if (v < -SUM_W'(33'sh80000000))
            sat = 32'h80000000;
        else
            sat = v[POS_W-1:0];
    endfunction

    always_comb
    begin
        xh = SUM_W'(cfg.box_length >> 1);
        yh = SUM_W'(cfg.box_height >> 1);
        zh = SUM_W'(cfg.box_width >> 1);
        pa = SUM_W'(a_pa_reg);
        pb = SUM_W'(a_pb_reg);
        nx = NORM_ZERO;
        ny = NORM_ZERO;
        nz = NORM_ZERO;
        case (a_face_reg)
            FACE_FRONT:
            begin
                px = pa - xh; py = yh - pb; pz = zh; nz = NORM_POS; col = 2'd0;
            end
            FACE_BACK:
            begin
                px = xh - pa; py = pb - yh; pz = -zh; nz = NORM_NEG; col = 2'd1;
            end
            FACE_TOP:
            begin
                px = pa - xh; py = yh; pz = zh - pb; ny = NORM_POS; col = 2'd2;
            end
            FACE_BOTTOM:
            begin
                px = xh - pa; py = -yh; pz = pb - zh; ny = NORM_NEG; col = 2'd0;
            end
            FACE_LEFT:
            begin
                px = -xh; py = yh - pb; pz = zh - pa; nx = NORM_NEG; col = 2'd1;
            end
            default:
            begin
                px = xh; py = pb - yh; pz = pa - zh; nx = NORM_POS; col = 2'd2;
            end
        endcase
        row = a_face_reg inside {FACE_BOTTOM, FACE_LEFT, FACE_RIGHT};
        case (col)
            2'd1:    begin ua = 17'd21845; ub = 2'd1; end
            2'd2:    begin ua = 17'd43690; ub = 2'd2; end
            default: begin ua = 17'd0;     ub = 2'd0; end
        endcase
        va = row ? 17'd32768 : 17'd0;
        du = RW'(n) * RW'(3);
        dv = RW'(n) * RW'(2);
        bn = RW'(ub) * RW'(n);
        cu = (bn + a_ur_reg) >= du;
        cv = a_vr_reg >= dv;
        us = (DIV_W + 1)'(a_uq_reg) + (DIV_W + 1)'(ua) + (DIV_W + 1)'(cu);
        vs = (DIV_W + 1)'(a_vq_reg) + (DIV_W + 1)'(va) + (DIV_W + 1)'(cv);
        tu = (us > (DIV_W + 1)'(TEX_ONE)) ? TEX_W'(TEX_ONE) : us[TEX_W-1:0];
        tv = (vs > (DIV_W + 1)'(TEX_ONE)) ? TEX_W'(TEX_ONE) : vs[TEX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {tv, tu, nz, ny, nx, sat(pz), sat(py), sat(px)};
            m_last_reg <= a_last_reg;
        end
    end

endmodule

// ===== tb/sv/box_mesh_cell_tessellator_tb.sv =====
// ----------------------------------------------------------------------------
// box_mesh_cell_tessellator_tb
// Sends grid cells under several box sizes and division counts and checks the
// 36 vertices of every cell against a built-in vertex predictor. Both stream
// sides idle in random bursts, except near the end.
// ----------------------------------------------------------------------------
module box_mesh_cell_tessellator_tb;
    import bmct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [1:0]  normal_x;
        logic [1:0]  normal_y;
        logic [1:0]  normal_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        last_vertex;
    } vertex_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;   // cell_i, cell_j
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;        // pos_x, pos_y, pos_z, normal_x/y/z, tex_u, tex_v
    logic         m_tlast;

    logic [30:0]  cur_length = 31'd65536;
    logic [30:0]  cur_width  = 31'd65536;
    logic [30:0]  cur_height = 31'd65536;
    logic [7:0]   cur_divs   = 8'd0;

    vertex_t      vertex_q[$];
    int unsigned  mismatches = 0;
    int unsigned  cells_sent = 0;
    int unsigned  vertices_seen = 0;
    longint unsigned cycles = 0;
    bit           idle_enable = 1'b1;

    localparam longint unsigned CYCLE_LIMIT = 2000000;

    box_mesh_cell_tessellator dut (.*);

    always #5 clk = ~clk;

    function automatic logic [31:0] sat_pos(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [16:0] atlas_coord(input longint unsigned tile,
                                                input longint unsigned k,
                                                input longint unsigned parts,
                                                input longint unsigned n);
        longint unsigned r;
        r = ((tile * n + k) * 65536) / (parts * n);
        return (r > 65536) ? 17'd65536 : r[16:0];
    endfunction

    task automatic predict_cell_vertices(input logic [7:0] ci, input logic [7:0] cj);
        longint unsigned n;
        longint xs, ys, zs, xh, yh, zh, sa, sb, px, py, pz;
        logic [5:0] pat0, pat1;
        logic pat;
        vertex_t vtx;
        pat0 = 6'b110001;
        pat1 = 6'b011100;
        n = cur_divs + 1;
        xs = cur_length / n;
        ys = cur_height / n;
        zs = cur_width / n;
        xh = cur_length >> 1;
        yh = cur_height >> 1;
        zh = cur_width >> 1;
        for (int f = 0; f < NUM_FACE; f++)
        begin
            pat = (f == FACE_BACK || f == FACE_TOP || f == FACE_LEFT);
            for (int k = 0; k < NUM_VERT; k++)
            begin
                sa = ci + (pat ? pat1[k] : pat0[k]);
                sb = cj + (pat ? pat0[k] : pat1[k]);
                vtx = '0;
                case (f)
                    FACE_FRONT:
                    begin
                        px = -xh + xs * sa; py = yh - ys * sb; pz = zh;
                        vtx.normal_z = NORM_POS;
                        vtx.tex_u = atlas_coord(0, sa, 3, n);
                        vtx.tex_v = atlas_coord(0, sb, 2, n);
                    end
                    FACE_BACK:
                    begin
                        px = xh - xs * sa; py = -yh + ys * sb; pz = -zh;
                        vtx.normal_z = NORM_NEG;
                        vtx.tex_u = atlas_coord(1, sa, 3, n);
                        vtx.tex_v = atlas_coord(0, sb, 2, n);
                    end
                    FACE_TOP:
                    begin
                        px = -xh + xs * sa; py = yh; pz = zh - zs * sb;
                        vtx.normal_y = NORM_POS;
                        vtx.tex_u = atlas_coord(2, sa, 3, n);
                        vtx.tex_v = atlas_coord(0, sb, 2, n);
                    end
                    FACE_BOTTOM:
                    begin
                        px = xh - xs * sa; py = -yh; pz = -zh + zs * sb;
                        vtx.normal_y = NORM_NEG;
                        vtx.tex_u = atlas_coord(0, sa, 3, n);
                        vtx.tex_v = atlas_coord(1, sb, 2, n);
                    end
                    FACE_LEFT:
                    begin
                        px = -xh; py = yh - ys * sb; pz = zh - zs * sa;
                        vtx.normal_x = NORM_NEG;
                        vtx.tex_u = atlas_coord(1, sb, 3, n);
                        vtx.tex_v = atlas_coord(1, sa, 2, n);
                    end
                    default:
                    begin
                        px = xh; py = -yh + ys * sb; pz = -zh + zs * sa;
                        vtx.normal_x = NORM_POS;
                        vtx.tex_u = atlas_coord(2, sa, 3, n);
                        vtx.tex_v = atlas_coord(1, sb, 2, n);
                    end
                endcase
                vtx.pos_x = sat_pos(px);
                vtx.pos_y = sat_pos(py);
                vtx.pos_z = sat_pos(pz);
                vtx.last_vertex = (f == FACE_RIGHT && k == NUM_VERT - 1);
                vertex_q.push_back(vtx);
            end
        end
    endtask

    task automatic send_cell(input logic [7:0] ci, input logic [7:0] cj);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cj, ci};
        do @(posedge clk); while (!s_tready);
        predict_cell_vertices(ci, cj);
        cells_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LENGTH: cur_length = value[30:0];
            REG_WIDTH:  cur_width  = value[30:0];
            REG_HEIGHT: cur_height = value[30:0];
            default:    cur_divs   = value[7:0];
        endcase
        @(posedge clk);
    endtask

    task automatic configure_box(input logic [30:0] len, input logic [30:0] wid,
                                 input logic [30:0] hgt, input logic [7:0] divs);
        s_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(REG_LENGTH, {1'b0, len});
        write_reg(REG_WIDTH, {1'b0, wid});
        write_reg(REG_HEIGHT, {1'b0, hgt});
        write_reg(REG_DIVS, {24'd0, divs});
    endtask

    // accept vertices and compare against the oldest prediction
    always @(posedge clk)
    begin
        vertex_t got, want;
        cycles <= cycles + 1;
        if (m_tvalid && m_tready)
        begin
            got.pos_x       = m_tdata[31:0];
            got.pos_y       = m_tdata[63:32];
            got.pos_z       = m_tdata[95:64];
            got.normal_x    = m_tdata[97:96];
            got.normal_y    = m_tdata[99:98];
            got.normal_z    = m_tdata[101:100];
            got.tex_u       = m_tdata[118:102];
            got.tex_v       = m_tdata[135:119];
            got.last_vertex = m_tlast;
            vertices_seen++;
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex %h", got);
            end
            else
            begin
                want = vertex_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex %0d mismatch: expected %h got %h",
                                 vertices_seen, want, got);
                end
            end
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge clk);
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("box_mesh_cell_tessellator_tb: FAIL");
        $finish;
    end

    task automatic test_reset_box();
        send_cell(8'd0, 8'd0);
        send_cell(8'd1, 8'd1);
        send_cell(8'd255, 8'd255);
    endtask

    task automatic test_grid_extremes();
        configure_box(31'd262144, 31'd131072, 31'd196608, 8'd255);
        send_cell(8'd0, 8'd0);
        send_cell(8'd255, 8'd0);
        send_cell(8'd0, 8'd255);
        send_cell(8'd255, 8'd255);
        send_cell(8'd170, 8'd85);
        send_cell(8'd85, 8'd170);
    endtask

    task automatic test_saturation();
        configure_box(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 8'd0);
        send_cell(8'd0, 8'd0);
        send_cell(8'd255, 8'd255);
        send_cell(8'd3, 8'd200);
        configure_box(31'd0, 31'd0, 31'd0, 8'd1);
        send_cell(8'd1, 8'd1);
        send_cell(8'd9, 8'd2);
    endtask

    task automatic test_random_cells(input int count, input bit in_grid);
        logic [7:0] hi;
        for (int i = 0; i < count; i++)
        begin
            hi = in_grid ? cur_divs : 8'd255;
            send_cell(8'($urandom_range(0, hi)), 8'($urandom_range(0, hi)));
        end
    endtask

    task automatic test_random_boxes();
        for (int p = 0; p < 6; p++)
        begin
            configure_box(31'($urandom >> $urandom_range(1, 13)),
                          31'($urandom >> $urandom_range(1, 13)),
                          31'($urandom >> $urandom_range(1, 13)),
                          (p % 2) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255)));
            test_random_cells(40, 1'b1);
            test_random_cells(8, 1'b0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_box();
        test_grid_extremes();
        test_saturation();
        test_random_boxes();
        idle_enable = 1'b0;
        configure_box(31'd327680, 31'd98304, 31'd65535, 8'd4);
        test_random_cells(20, 1'b1);
        s_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d cells over reset, extreme, saturating and random boxes,",
                 cells_sent);
        $display("checked %0d vertices.", vertices_seen);
        if (mismatches == 0)
            $display("box_mesh_cell_tessellator_tb: PASS");
        else
            $display("box_mesh_cell_tessellator_tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/bmct_pkg.sv
rtl/core/bmct_front.sv
rtl/core/bmct_queue.sv
rtl/core/bmct_back.sv
rtl/core/box_mesh_cell_tessellator.sv
tb/sv/box_mesh_cell_tessellator_tb.sv
